// ===== sv/usplit_pkg.sv =====
// usplit_pkg: types and constants shared by the URL splitter modules.
// Parse state, result record, phase and code names, scheme letter lookup.
// No dependencies.
package usplit_pkg;

    // parse phase
    typedef enum logic [3:0] {
        PH_H          = 4'd0,
        PH_T1         = 4'd1,
        PH_T2         = 4'd2,
        PH_P          = 4'd3,
        PH_SCHEME_END = 4'd4,
        PH_AFTER_S    = 4'd5,
        PH_SLASH1     = 4'd6,
        PH_SLASH2     = 4'd7,
        PH_HOST       = 4'd8,
        PH_PORT       = 4'd9,
        PH_PATH       = 4'd10,
        PH_SKIP       = 4'd11
    } t_phase;

    // byte roles
    typedef enum logic [2:0] {
        ROLE_SCHEME  = 3'd0,
        ROLE_SEP     = 3'd1,
        ROLE_HOST    = 3'd2,
        ROLE_PORT    = 3'd3,
        ROLE_PATH    = 3'd4,
        ROLE_IGNORED = 3'd5
    } t_role;

    // status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_PROTOCOL  = 3'd2,
        ST_TERM      = 3'd3,
        ST_NO_HOST   = 3'd4,
        ST_PORT_RNG  = 3'd5,
        ST_PORT_CHAR = 3'd6
    } t_status;

    localparam logic [7:0]  CH_COLON     = 8'h3A;
    localparam logic [7:0]  CH_SLASH     = 8'h2F;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_NINE      = 8'h39;
    localparam logic [7:0]  CH_LOWER_S   = 8'h73;
    localparam logic [7:0]  CNT_MAX      = 8'hFF;
    localparam logic [16:0] PORT_SAT     = 17'd65536;
    localparam logic [15:0] PORT_HTTP    = 16'd80;
    localparam logic [15:0] PORT_HTTPS   = 16'd443;
    localparam logic [7:0]  MIN_LEN_RST  = 8'd8;

    typedef struct packed {
        t_phase      phase;
        logic [16:0] port_acc;
        logic        digits_seen;
        logic        ssl;
        logic        host_seen;
        logic        path_seen;
        logic [7:0]  byte_count;
        t_status     err;
    } t_parse_state;

    localparam t_parse_state STATE_RST = '{
        phase: PH_H, port_acc: 17'd0, digits_seen: 1'b0, ssl: 1'b0,
        host_seen: 1'b0, path_seen: 1'b0, byte_count: 8'd0, err: ST_OK
    };

    typedef struct packed {
        t_role       role;
        logic        done;
        t_status     status;
        logic        use_ssl;
        logic [15:0] port;
        logic        has_path;
    } t_result;

    // expected lower-case scheme letter for phases 0..3 ("http")
    function automatic logic [7:0] scheme_letter(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h68;
            2'd1:    c = 8'h74;
            2'd2:    c = 8'h74;
            default: c = 8'h70;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

// ===== sv/usplit_step.sv =====
// usplit_step: combinational parse step for one URL byte.
// Computes next parse state and the result record from the current state.
// Depends on usplit_pkg.
module usplit_step
    import usplit_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_ch,
    input  logic         i_last,
    input  logic [7:0]   i_min_length,
    output t_parse_state o_state,
    output t_result      o_result
);

    always_comb begin
        t_parse_state s;
        t_status      err;
        t_status      fin_err;
        t_status      status;
        t_role        role;
        logic [7:0]   lc;
        logic [19:0]  acc10;

        s       = i_state;
        err     = ST_OK;
        role    = ROLE_IGNORED;
        lc      = to_lower(i_ch);
        // acc * 10 + digit, with the multiply as two shifts
        acc10   = {i_state.port_acc, 3'b000} + {2'b00, i_state.port_acc, 1'b0}
                  + {12'd0, i_ch - CH_ZERO};
        fin_err = ST_OK;
        status  = ST_OK;

        if (s.byte_count != CNT_MAX) begin
            s.byte_count = s.byte_count + 8'd1;
        end

        // per-phase byte handling
        case (i_state.phase)
            PH_H, PH_T1, PH_T2, PH_P: begin
                if (lc == scheme_letter(i_state.phase[1:0])) begin
                    role    = ROLE_SCHEME;
                    s.phase = t_phase'(i_state.phase + 4'd1);
                end else begin
                    err = ST_PROTOCOL;
                end
            end
            PH_SCHEME_END: begin
                if (lc == CH_LOWER_S) begin
                    s.ssl   = 1'b1;
                    role    = ROLE_SCHEME;
                    s.phase = PH_AFTER_S;
                end else if (i_ch == CH_COLON) begin
                    role    = ROLE_SEP;
                    s.phase = PH_SLASH1;
                end else begin
                    err = ST_TERM;
                end
            end
            PH_AFTER_S: begin
                if (i_ch == CH_COLON) begin
                    role    = ROLE_SEP;
                    s.phase = PH_SLASH1;
                end else begin
                    err = ST_TERM;
                end
            end
            PH_SLASH1: begin
                if (i_ch == CH_SLASH) begin
                    role    = ROLE_SEP;
                    s.phase = PH_SLASH2;
                end else begin
                    err = ST_TERM;
                end
            end
            PH_SLASH2: begin
                if (i_ch == CH_SLASH) begin
                    role    = ROLE_SEP;
                    s.phase = PH_HOST;
                end else begin
                    err = ST_TERM;
                end
            end
            PH_HOST: begin
                if (i_ch == CH_COLON || i_ch == CH_SLASH) begin
                    if (!i_state.host_seen) begin
                        err = ST_NO_HOST;
                    end else if (i_ch == CH_COLON) begin
                        role    = ROLE_SEP;
                        s.phase = PH_PORT;
                    end else begin
                        role        = ROLE_PATH;
                        s.path_seen = 1'b1;
                        s.phase     = PH_PATH;
                    end
                end else begin
                    s.host_seen = 1'b1;
                    role        = ROLE_HOST;
                end
            end
            PH_PORT: begin
                if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
                    s.port_acc    = (acc10 > {3'd0, PORT_SAT}) ? PORT_SAT : acc10[16:0];
                    s.digits_seen = 1'b1;
                    role          = ROLE_PORT;
                end else if (i_state.port_acc[16]) begin
                    err = ST_PORT_RNG;
                end else if (i_ch == CH_SLASH) begin
                    role        = ROLE_PATH;
                    s.path_seen = 1'b1;
                    s.phase     = PH_PATH;
                end else begin
                    err = ST_PORT_CHAR;
                end
            end
            PH_PATH: begin
                role = ROLE_PATH;
            end
            default: begin
                role = ROLE_IGNORED;
            end
        endcase

        // first error wins; rest of the URL is skipped
        if (err != ST_OK) begin
            s.err   = err;
            s.phase = PH_SKIP;
            role    = ROLE_IGNORED;
        end

        // end-of-URL checks
        fin_err = s.err;
        if (s.err == ST_OK) begin
            if (s.phase < PH_SCHEME_END) begin
                fin_err = ST_PROTOCOL;
            end else if (s.phase < PH_HOST) begin
                fin_err = ST_TERM;
            end else if (s.phase == PH_HOST && !s.host_seen) begin
                fin_err = ST_NO_HOST;
            end else if (s.phase == PH_PORT && s.port_acc[16]) begin
                fin_err = ST_PORT_RNG;
            end
        end
        status = (s.byte_count < i_min_length) ? ST_SHORT : fin_err;

        o_result.role     = role;
        o_result.done     = i_last;
        o_result.status   = ST_OK;
        o_result.use_ssl  = 1'b0;
        o_result.port     = 16'd0;
        o_result.has_path = 1'b0;
        if (i_last) begin
            o_result.status = status;
            if (status == ST_OK) begin
                o_result.use_ssl  = s.ssl;
                o_result.port     = s.digits_seen ? s.port_acc[15:0]
                                  : (s.ssl ? PORT_HTTPS : PORT_HTTP);
                o_result.has_path = s.path_seen;
            end
            o_state = STATE_RST;
        end else begin
            o_state = s;
        end
    end

endmodule

// ===== sv/http_url_splitter_core.sv =====
// http_url_splitter_core: top level of the byte-serial http/https URL splitter.
// Input beat register, parse state register, result register.
// Depends on usplit_pkg and usplit_step.

// Takes one URL byte per beat on s_axis (tlast on the final byte) and returns one
// result beat per input beat on m_axis, in order. Throughput is one byte per cycle
// while m_axis_tready stays high. A byte accepted on s_axis is held in the input
// register, passes through the combinational parse step and is shown on m_axis
// from the result register. The parse state updates as a byte moves into the
// result register, and it returns to reset after each final byte. min_length is
// written through the cfg channel (always ready); the user must write it only
// while the stream is idle, as the block does not enforce this. It resets to 8.
module http_url_splitter_core
    import usplit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,    // min_length
    // byte input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    input  logic        s_axis_tlast,  // last
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [2:0] status, [3] use_ssl, [19:4] port,
                                       // [20] has_path, [23:21] zero
    output logic [2:0]  m_axis_tuser,  // [2:0] role
    output logic        m_axis_tlast   // done_res
);

    logic         r_in_valid;
    logic [7:0]   r_in_ch;
    logic         r_in_last;
    logic         r_out_valid;
    t_result      r_out;
    t_parse_state r_state;
    logic [7:0]   r_min_length;

    t_parse_state n_state;
    t_result      n_out;
    logic         advance;

    // parse step
    usplit_step u_step (
        .i_state      (r_state),
        .i_ch         (r_in_ch),
        .i_last       (r_in_last),
        .i_min_length (r_min_length),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    // handshake: input beat moves on when the result slot is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LEN_RST;
        end else if (i_cfg_valid) begin
            r_min_length <= i_cfg_data;
        end
    end

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch   <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.role;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tdata  = {3'b000, r_out.has_path, r_out.port, r_out.use_ssl, r_out.status};

endmodule
